### hw/rtl/ofps_pkg.sv
// shared types and constants for the oled page streamer
// beat structs, phase and step codes, control word and status bundles
// no dependencies
package ofps_pkg;

    localparam logic [2:0] OP_SET_PIXEL = 3'd0;
    localparam logic [2:0] OP_FILL      = 3'd1;
    localparam logic [2:0] OP_FLUSH     = 3'd2;
    localparam logic [2:0] OP_INIT      = 3'd3;
    localparam logic [2:0] OP_TICK      = 3'd4;

    localparam int         INIT_LEN      = 25;
    localparam logic [7:0] HDR_PAGE_BASE = 8'hB0;
    localparam logic [7:0] HDR_COL_LO    = 8'h00;
    localparam logic [7:0] HDR_COL_HI    = 8'h10;
    localparam logic [7:0] FILL_WHITE    = 8'hFF;
    localparam logic [7:0] FILL_BLACK    = 8'h00;

    typedef struct packed {
        logic [2:0] operation;
        logic [7:0] x_coord;
        logic [6:0] y_coord;
        logic       pixel_value;
    } t_in;

    typedef struct packed {
        logic [7:0] spi_byte;
        logic       is_data;
        logic       sequence_end;
    } t_out;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_INIT,
        PH_HEADER,
        PH_DATA
    } t_phase;

    typedef enum logic [3:0] {
        S_FETCH,
        S_PIX_RD,
        S_PIX_WR,
        S_FILL,
        S_FLUSH,
        S_INIT,
        S_TICK_INIT,
        S_TICK_HDR,
        S_DATA_RD,
        S_DATA_EMIT,
        S_SWEEP
    } t_step;

    typedef enum logic [1:0] {
        AS_PIXEL,
        AS_DATA,
        AS_SWEEP
    } t_addr_sel;

    typedef enum logic [2:0] {
        ACT_NONE,
        ACT_FILL,
        ACT_FLUSH,
        ACT_INIT,
        ACT_EMIT_INIT,
        ACT_EMIT_HDR,
        ACT_EMIT_DATA,
        ACT_SWEEP
    } t_act;

    typedef enum logic [2:0] {
        J_NEXT,
        J_GOTO,
        J_DISPATCH,
        J_INIT_LAST,
        J_SWEEP_LAST
    } t_jmp;

    typedef struct packed {
        logic      in_rdy;
        logic      wait_out;
        logic      mem_rd;
        logic      mem_wr;
        t_addr_sel addr_sel;
        t_act      act;
        t_jmp      jmp;
        t_step     target;
    } t_ctrl;

    typedef struct packed {
        logic       in_acc;
        logic [2:0] op;
        t_phase     phase;
        logic       pix_ok;
        logic       out_free;
        logic       init_last;
        logic       sweep_last;
    } t_status;

    function automatic logic [7:0] init_byte(input logic [4:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = 8'hAE;
            5'd1:    b = 8'hD5;
            5'd2:    b = 8'h80;
            5'd3:    b = 8'hA8;
            5'd4:    b = 8'h3F;
            5'd5:    b = 8'hD3;
            5'd6:    b = 8'h00;
            5'd7:    b = 8'h40;
            5'd8:    b = 8'h8D;
            5'd9:    b = 8'h14;
            5'd10:   b = 8'h20;
            5'd11:   b = 8'h00;
            5'd12:   b = 8'hA1;
            5'd13:   b = 8'hC8;
            5'd14:   b = 8'hDA;
            5'd15:   b = 8'h12;
            5'd16:   b = 8'h81;
            5'd17:   b = 8'hCF;
            5'd18:   b = 8'hD9;
            5'd19:   b = 8'hF1;
            5'd20:   b = 8'hDB;
            5'd21:   b = 8'h40;
            5'd22:   b = 8'hA4;
            5'd23:   b = 8'hA6;
            5'd24:   b = 8'hAF;
            default: b = 8'hAE;
        endcase
        return b;
    endfunction

endpackage

### hw/rtl/ofps_ucode_rom.sv
// microcode table: one control word per sequencer step
// depends on ofps_pkg
module ofps_ucode_rom
    import ofps_pkg::*;
(
    input  t_step i_step,
    output t_ctrl o_ctrl
);

    always_comb begin
        o_ctrl          = '0;
        o_ctrl.addr_sel = AS_PIXEL;
        o_ctrl.act      = ACT_NONE;
        o_ctrl.jmp      = J_GOTO;
        o_ctrl.target   = S_FETCH;
        case (i_step)
            S_FETCH: begin
                o_ctrl.in_rdy = 1'b1;
                o_ctrl.jmp    = J_DISPATCH;
            end
            S_PIX_RD: begin
                o_ctrl.mem_rd   = 1'b1;
                o_ctrl.addr_sel = AS_PIXEL;
                o_ctrl.jmp      = J_NEXT;
            end
            S_PIX_WR: begin
                o_ctrl.mem_wr   = 1'b1;
                o_ctrl.addr_sel = AS_PIXEL;
            end
            S_FILL: begin
                o_ctrl.act    = ACT_FILL;
                o_ctrl.target = S_SWEEP;
            end
            S_FLUSH: begin
                o_ctrl.act = ACT_FLUSH;
            end
            S_INIT: begin
                o_ctrl.act = ACT_INIT;
            end
            S_TICK_INIT: begin
                o_ctrl.wait_out = 1'b1;
                o_ctrl.act      = ACT_EMIT_INIT;
                o_ctrl.jmp      = J_INIT_LAST;
                o_ctrl.target   = S_SWEEP;
            end
            S_TICK_HDR: begin
                o_ctrl.wait_out = 1'b1;
                o_ctrl.act      = ACT_EMIT_HDR;
            end
            S_DATA_RD: begin
                o_ctrl.mem_rd   = 1'b1;
                o_ctrl.addr_sel = AS_DATA;
                o_ctrl.jmp      = J_NEXT;
            end
            S_DATA_EMIT: begin
                o_ctrl.wait_out = 1'b1;
                o_ctrl.act      = ACT_EMIT_DATA;
            end
            S_SWEEP: begin
                o_ctrl.mem_wr   = 1'b1;
                o_ctrl.addr_sel = AS_SWEEP;
                o_ctrl.act      = ACT_SWEEP;
                o_ctrl.jmp      = J_SWEEP_LAST;
                o_ctrl.target   = S_FETCH;
            end
            default: begin
                o_ctrl.target = S_FETCH;
            end
        endcase
    end

endmodule

### hw/rtl/ofps_sequencer.sv
// step counter with conditional and dispatch jumps over the microcode table
// depends on ofps_pkg and ofps_ucode_rom
module ofps_sequencer
    import ofps_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_ctrl   o_ctrl
);

    t_step r_step;
    t_step n_step;
    t_step dispatch;
    t_ctrl ctrl;

    ofps_ucode_rom u_rom (
        .i_step (r_step),
        .o_ctrl (ctrl)
    );

    assign o_ctrl = ctrl;

    always_comb begin
        case (i_status.op)
            OP_SET_PIXEL: dispatch = i_status.pix_ok ? S_PIX_RD : S_FETCH;
            OP_FILL:      dispatch = S_FILL;
            OP_FLUSH:     dispatch = (i_status.phase == PH_IDLE) ? S_FLUSH : S_FETCH;
            OP_INIT:      dispatch = (i_status.phase == PH_IDLE) ? S_INIT : S_FETCH;
            OP_TICK: begin
                case (i_status.phase)
                    PH_INIT:   dispatch = S_TICK_INIT;
                    PH_HEADER: dispatch = S_TICK_HDR;
                    PH_DATA:   dispatch = S_DATA_RD;
                    default:   dispatch = S_FETCH;
                endcase
            end
            default:      dispatch = S_FETCH;
        endcase
    end

    always_comb begin
        n_step = r_step;
        if (!(ctrl.wait_out && !i_status.out_free)) begin
            case (ctrl.jmp)
                J_NEXT:       n_step = t_step'(r_step + 4'd1);
                J_GOTO:       n_step = ctrl.target;
                J_DISPATCH:   n_step = i_status.in_acc ? dispatch : r_step;
                J_INIT_LAST:  n_step = i_status.init_last ? ctrl.target : S_FETCH;
                J_SWEEP_LAST: n_step = i_status.sweep_last ? ctrl.target : r_step;
                default:      n_step = S_FETCH;
            endcase
        end
    end

    // reset enters the clearing pass
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= S_SWEEP;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

### hw/rtl/ofps_fb_mem.sv
// frame buffer storage, one write and one registered read per cycle
// no package dependencies
module ofps_fb_mem #(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] mem [DEPTH];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### hw/rtl/ofps_datapath.sv
// datapath: item capture, refresh counters, pixel update, output register
// depends on ofps_pkg and ofps_fb_mem
module ofps_datapath
    import ofps_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_ctrl   i_ctrl,
    input  logic    i_in_valid,
    input  t_in     i_in,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    output t_out    o_out,
    output t_status o_status
);

    localparam int DEPTH = COLUMNS * PAGES;
    localparam int AW    = $clog2(DEPTH);
    localparam int PW    = (PAGES > 1) ? $clog2(PAGES) : 1;
    localparam int CW    = $clog2(COLUMNS);

    t_in           r_item;
    t_phase        r_phase,      n_phase;
    logic [4:0]    r_init_idx,   n_init_idx;
    logic [PW-1:0] r_page,       n_page;
    logic [CW-1:0] r_col,        n_col;
    logic [1:0]    r_slot,       n_slot;
    logic [AW-1:0] r_sweep_addr, n_sweep_addr;
    logic [7:0]    r_sweep_val,  n_sweep_val;
    t_out          r_out,        n_out;
    logic          r_out_vld,    n_out_vld;

    logic          in_acc;
    logic          out_free;
    logic          go;
    logic          emit;
    logic [PW-1:0] pix_page;
    logic [7:0]    pix_mask;
    logic [AW-1:0] pix_addr;
    logic [AW-1:0] data_addr;
    logic [AW-1:0] mem_addr;
    logic [7:0]    mem_wdata;
    logic [7:0]    rdata;
    logic          init_last;
    logic          sweep_last;

    assign in_acc     = i_in_valid && i_ctrl.in_rdy;
    assign out_free   = !r_out_vld || i_out_ready;
    assign go         = !(i_ctrl.wait_out && !out_free);
    assign init_last  = (r_init_idx == 5'(INIT_LEN - 1));
    assign sweep_last = (r_sweep_addr == AW'(DEPTH - 1));

    assign pix_page  = PW'(r_item.y_coord[6:3]);
    assign pix_mask  = 8'd1 << r_item.y_coord[2:0];
    assign pix_addr  = AW'(r_item.x_coord) * AW'(PAGES) + AW'(pix_page);
    assign data_addr = AW'(r_col) * AW'(PAGES) + AW'(r_page);

    always_comb begin
        case (i_ctrl.addr_sel)
            AS_PIXEL: mem_addr = pix_addr;
            AS_DATA:  mem_addr = data_addr;
            AS_SWEEP: mem_addr = r_sweep_addr;
            default:  mem_addr = r_sweep_addr;
        endcase
    end

    always_comb begin
        if (i_ctrl.addr_sel == AS_SWEEP) begin
            mem_wdata = r_sweep_val;
        end else if (r_item.pixel_value) begin
            mem_wdata = rdata | pix_mask;
        end else begin
            mem_wdata = rdata & ~pix_mask;
        end
    end

    ofps_fb_mem #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (i_ctrl.mem_wr),
        .i_waddr (mem_addr),
        .i_wdata (mem_wdata),
        .i_re    (i_ctrl.mem_rd),
        .i_raddr (mem_addr),
        .o_rdata (rdata)
    );

    always_comb begin
        n_phase      = r_phase;
        n_init_idx   = r_init_idx;
        n_page       = r_page;
        n_col        = r_col;
        n_slot       = r_slot;
        n_sweep_addr = r_sweep_addr;
        n_sweep_val  = r_sweep_val;
        n_out        = r_out;
        emit         = 1'b0;
        if (go) begin
            case (i_ctrl.act)
                ACT_FILL: begin
                    n_sweep_val  = r_item.pixel_value ? FILL_WHITE : FILL_BLACK;
                    n_sweep_addr = '0;
                end
                ACT_FLUSH: begin
                    n_phase = PH_HEADER;
                    n_page  = '0;
                    n_col   = '0;
                    n_slot  = '0;
                end
                ACT_INIT: begin
                    n_phase    = PH_INIT;
                    n_init_idx = '0;
                end
                ACT_EMIT_INIT: begin
                    emit  = 1'b1;
                    n_out = '{spi_byte: init_byte(r_init_idx), is_data: 1'b0,
                              sequence_end: 1'b0};
                    n_init_idx = r_init_idx + 5'd1;
                    if (init_last) begin
                        // command list done: clear buffer, then flush
                        n_init_idx   = '0;
                        n_phase      = PH_HEADER;
                        n_page       = '0;
                        n_col        = '0;
                        n_slot       = '0;
                        n_sweep_val  = FILL_BLACK;
                        n_sweep_addr = '0;
                    end
                end
                ACT_EMIT_HDR: begin
                    emit             = 1'b1;
                    n_out.is_data    = 1'b0;
                    n_out.sequence_end = 1'b0;
                    case (r_slot)
                        2'd0:    n_out.spi_byte = HDR_PAGE_BASE + 8'(r_page);
                        2'd1:    n_out.spi_byte = HDR_COL_LO;
                        default: n_out.spi_byte = HDR_COL_HI;
                    endcase
                    n_slot = r_slot + 2'd1;
                    if (r_slot == 2'd2) begin
                        n_slot  = '0;
                        n_col   = '0;
                        n_phase = PH_DATA;
                    end
                end
                ACT_EMIT_DATA: begin
                    emit  = 1'b1;
                    n_out = '{spi_byte: rdata, is_data: 1'b1, sequence_end: 1'b0};
                    n_col = r_col + CW'(1);
                    if (r_col == CW'(COLUMNS - 1)) begin
                        n_col = '0;
                        if (r_page == PW'(PAGES - 1)) begin
                            n_page             = '0;
                            n_phase            = PH_IDLE;
                            n_out.sequence_end = 1'b1;
                        end else begin
                            n_page  = r_page + PW'(1);
                            n_phase = PH_HEADER;
                        end
                    end
                end
                ACT_SWEEP: begin
                    n_sweep_addr = r_sweep_addr + AW'(1);
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
        if (emit) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_init_idx   <= '0;
            r_page       <= '0;
            r_col        <= '0;
            r_slot       <= '0;
            r_sweep_addr <= '0;
            r_sweep_val  <= FILL_BLACK;
            r_out_vld    <= 1'b0;
        end else begin
            r_phase      <= n_phase;
            r_init_idx   <= n_init_idx;
            r_page       <= n_page;
            r_col        <= n_col;
            r_slot       <= n_slot;
            r_sweep_addr <= n_sweep_addr;
            r_sweep_val  <= n_sweep_val;
            r_out_vld    <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_item <= i_in;
        end
        r_out <= n_out;
    end

    always_comb begin
        o_status.in_acc     = in_acc;
        o_status.op         = i_in.operation;
        o_status.phase      = r_phase;
        o_status.pix_ok     = ({1'b0, i_in.x_coord} < 9'(COLUMNS))
                           && ({1'b0, i_in.y_coord} < 8'(8 * PAGES));
        o_status.out_free   = out_free;
        o_status.init_last  = init_last;
        o_status.sweep_last = sweep_last;
    end

    assign o_out_valid = r_out_vld;
    assign o_out       = r_out;

endmodule

### hw/rtl/oled_framebuffer_page_streamer_top.sv
// oled page streamer: header and init ticks emit into the result register from their emit step,
// data ticks read the buffer byte first; the next beat is taken only once back at the fetch step
// fill and the last init tick sweep all COLUMNS*PAGES bytes, one buffer byte written per cycle
// result register lets the next beat in while a byte waits on the output
// reset clears control, then a clearing pass over all COLUMNS*PAGES bytes holds o_in_ready low
// depends on ofps_pkg, ofps_sequencer, ofps_datapath
module oled_framebuffer_page_streamer_top
    import ofps_pkg::*;
#(
    parameter int COLUMNS = 128,
    parameter int PAGES   = 8
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    t_ctrl   ctrl;
    t_status status;

    ofps_sequencer u_seq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    ofps_datapath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_in_valid  (i_in_valid),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .o_status    (status)
    );

    assign o_in_ready = ctrl.in_rdy;

endmodule

### hw/rtl/ofps_checker.sv
// port-level checks for the oled page streamer, bound to the top level
// depends on ofps_pkg
module ofps_checker
    import ofps_pkg::*;
(
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic o_in_ready,
    input t_in  i_in,
    input logic o_out_valid,
    input logic i_out_ready,
    input t_out o_out
);

    // held beat keeps valid
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("output beat dropped before accept");

    // held beat keeps payload
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> $stable(o_out))
        else $error("output payload changed while stalled");

    // sequence end only on a data byte
    a_end_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out.sequence_end |-> o_out.is_data)
        else $error("sequence end on a command byte");

    // clearing pass follows reset
    a_clear_after_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready && !o_out_valid)
        else $error("input taken during clearing pass");

endmodule

bind oled_framebuffer_page_streamer_top ofps_checker u_ofps_checker (.*);
